// ===== src/row_transposition_cipher_core_defines.svh =====
// assertion macros shared by the row transposition cipher core
`ifndef ROW_TRANSPOSITION_CIPHER_CORE_DEFINES_SVH
`define ROW_TRANSPOSITION_CIPHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent in one cycle implies consequent in the next
`define RTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
// antecedent implies consequent in the same cycle
`define RTC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`else
`define RTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define RTC_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/rtc_pkg.sv =====
// types and constants shared by the row transposition cipher core
package rtc_pkg;

   // grid row count register width and its largest value
   localparam int ROW_W   = 7;
   localparam int ROW_MAX = 127;

   // padding byte for unfilled cells
   localparam logic [7:0] FILLER = 8'd45;

   // result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_OVERFLOW = 2'd1;
   localparam logic [1:0] STAT_GRID     = 2'd2;
   localparam logic [1:0] STAT_EMPTY    = 2'd3;

   // register indexes
   localparam logic REG_ROW_COUNT = 1'b0;
   localparam logic REG_DECRYPT   = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_count;
      logic             decrypt;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       prep;
      logic       div_step;
      logic       scan_init;
      logic       scan_run;
      logic       final_emit;
      logic [1:0] final_code;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic overflow;
      logic grid_big;
      logic scan_empty;
      logic adv;
   } stat_type;

endpackage

// ===== src/rtc_csr.sv =====
// configuration registers behind the apb-style port
module rtc_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output rtc_pkg::cfg_type   cfg
);
   import rtc_pkg::*;

   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic             decrypt_ff, decrypt_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // register write decode
   always_comb begin
      row_count_in = row_count_ff;
      decrypt_in   = decrypt_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_ROW_COUNT: row_count_in = csr_pwdata[ROW_W-1:0];
            REG_DECRYPT:   decrypt_in   = csr_pwdata[0];
            default:       row_count_in = row_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_W'(1);
         decrypt_ff   <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         decrypt_ff   <= decrypt_in;
      end
   end

   // read mux
   always_comb begin
      unique case (csr_paddr[2])
         REG_ROW_COUNT: csr_prdata = {{(32-ROW_W){1'b0}}, row_count_ff};
         REG_DECRYPT:   csr_prdata = {31'd0, decrypt_ff};
         default:       csr_prdata = 32'd0;
      endcase
   end

   assign cfg.row_count = row_count_ff;
   assign cfg.decrypt   = decrypt_ff;

endmodule

// ===== src/rtc_ctrl.sv =====
// sequencing state machine of the row transposition cipher core
module rtc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last,
   output logic               req_ready,
   input  rtc_pkg::stat_type  stat,
   output rtc_pkg::cmd_type   cmd
);
   import rtc_pkg::*;

   typedef enum logic [6:0] {
      ST_LOAD  = 7'b0000001,
      ST_PREP  = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_CHECK = 7'b0010000,
      ST_SCAN  = 7'b0100000,
      ST_FINAL = 7'b1000000
   } phase_type;

   phase_type  state_ff, state_in;
   logic [1:0] code_ff, code_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.final_code = code_ff;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.overflow) begin
               code_in  = STAT_OVERFLOW;
               state_in = ST_FINAL;
            end else if (stat.grid_big) begin
               code_in  = STAT_GRID;
               state_in = ST_FINAL;
            end else begin
               code_in       = STAT_EMPTY;
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_empty) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.final_emit = 1'b1;
            if (stat.adv) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         code_ff  <= STAT_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

// ===== src/rtc_datapath.sv =====
// message store, column divider, grid scan and result register
module rtc_datapath #(
   parameter int MAX_LEN = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  rtc_pkg::req_type   req_data,
   input  rtc_pkg::cfg_type   cfg,
   input  rtc_pkg::cmd_type   cmd,
   output rtc_pkg::stat_type  stat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rtc_pkg::rsp_type   rsp_data
);
   import rtc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int ADR_W  = $clog2(MAX_LEN);
   localparam int NUM_W  = $clog2(MAX_LEN + ROW_MAX);
   localparam int DCNT_W = $clog2(NUM_W);
   localparam int IDX_W  = $clog2(MAX_LEN + ROW_MAX);
   localparam int PROD_W = ROW_W + CNT_W;

   // message store
   logic [7:0]       store_ff [MAX_LEN];
   logic [7:0]       rd_data_ff;

   logic [CNT_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic             ovf_ff, ovf_in;
   logic [ROW_W-1:0] rows_ff, rows_in;
   logic             dec_ff, dec_in;

   // divider
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [ROW_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // scan counters and pipeline
   logic [ROW_W-1:0] inner_ff, inner_in;
   logic [ROW_W-1:0] outer_ff, outer_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             s0_vld_ff, s0_vld_in;
   logic             s1_vld_ff, s1_vld_in;
   logic             s1_in_ff, s1_in_in;
   logic             p_vld_ff, p_vld_in;
   logic [7:0]       p_byte_ff, p_byte_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_vld_ff, rsp_vld_in;

   logic             adv;
   logic             store_full;
   logic [CNT_W-1:0] cols;
   logic [ROW_W-1:0] cols_w;
   logic [ROW_W-1:0] stride;
   logic [ROW_W-1:0] inner_n;
   logic [ROW_W-1:0] outer_n;
   logic [ROW_W:0]   rem_sh;
   logic [ROW_W:0]   rem_sub;
   logic             div_ge;
   logic             cell_in;
   logic             emit_cell;
   logic             rsp_load;

   assign adv        = !rsp_vld_ff || rsp_ready;
   assign store_full = (byte_cnt_ff == CNT_W'(MAX_LEN));
   assign cols       = num_ff[CNT_W-1:0];
   assign cols_w     = ROW_W'(cols);
   assign stride     = dec_ff ? cols_w : rows_ff;
   assign inner_n    = dec_ff ? rows_ff : cols_w;
   assign outer_n    = dec_ff ? cols_w : rows_ff;

   // one restoring division step per cycle
   assign rem_sh  = {rem_ff, num_ff[NUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, rows_ff};
   assign div_ge  = (rem_sh >= {1'b0, rows_ff});

   // cell in message range, and whether it yields a word
   // encrypt emits every cell, padding the unfilled ones
   assign cell_in   = (idx_ff < IDX_W'(byte_cnt_ff));
   assign emit_cell = s1_vld_ff && (!dec_ff || (s1_in_ff && (rd_data_ff != FILLER)));

   always_comb begin
      byte_cnt_in = byte_cnt_ff;
      ovf_in      = ovf_ff;
      rows_in     = rows_ff;
      dec_in      = dec_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      div_cnt_in  = div_cnt_ff;
      prod_in     = PROD_W'(rows_ff) * PROD_W'(cols);
      inner_in    = inner_ff;
      outer_in    = outer_ff;
      idx_in      = idx_ff;
      s0_vld_in   = s0_vld_ff;
      s1_vld_in   = s1_vld_ff;
      s1_in_in    = s1_in_ff;
      p_vld_in    = p_vld_ff;
      p_byte_in   = p_byte_ff;
      rsp_in      = rsp_ff;
      rsp_load    = 1'b0;

      // byte load, settings captured at the last byte
      if (cmd.load) begin
         if (!store_full) begin
            byte_cnt_in = byte_cnt_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (req_data.in_last) begin
            rows_in = (cfg.row_count == '0) ? ROW_W'(1) : cfg.row_count;
            dec_in  = cfg.decrypt;
         end
      end

      // column count as ceil(length / rows)
      if (cmd.prep) begin
         num_in     = NUM_W'(byte_cnt_ff) + NUM_W'(rows_ff) - NUM_W'(1);
         rem_in     = '0;
         div_cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in     = div_ge ? rem_sub[ROW_W-1:0] : rem_sh[ROW_W-1:0];
         num_in     = {num_ff[NUM_W-2:0], div_ge};
         div_cnt_in = div_cnt_ff + DCNT_W'(1);
      end

      // grid scan start
      if (cmd.scan_init) begin
         inner_in  = '0;
         outer_in  = '0;
         idx_in    = '0;
         s0_vld_in = 1'b1;
         s1_vld_in = 1'b0;
         p_vld_in  = 1'b0;
      end

      // scan step: address, store read, pending word
      if (cmd.scan_run && adv) begin
         s1_vld_in = s0_vld_ff;
         s1_in_in  = cell_in;
         if (s0_vld_ff) begin
            if (inner_ff == inner_n - ROW_W'(1)) begin
               inner_in = '0;
               if (outer_ff == outer_n - ROW_W'(1)) begin
                  s0_vld_in = 1'b0;
               end else begin
                  outer_in = outer_ff + ROW_W'(1);
                  idx_in   = IDX_W'(outer_ff) + IDX_W'(1);
               end
            end else begin
               inner_in = inner_ff + ROW_W'(1);
               idx_in   = idx_ff + IDX_W'(stride);
            end
         end
         if (emit_cell) begin
            p_byte_in = s1_in_ff ? rd_data_ff : FILLER;
            p_vld_in  = 1'b1;
            if (p_vld_ff) begin
               rsp_in   = '{out_byte: p_byte_ff, out_last: 1'b0, status: STAT_OK};
               rsp_load = 1'b1;
            end
         end
      end

      // closing word of the run
      if (cmd.final_emit && adv) begin
         if (p_vld_ff) begin
            rsp_in = '{out_byte: p_byte_ff, out_last: 1'b1, status: STAT_OK};
         end else begin
            rsp_in = '{out_byte: 8'd0, out_last: 1'b1, status: cmd.final_code};
         end
         rsp_load    = 1'b1;
         p_vld_in    = 1'b0;
         byte_cnt_in = '0;
         ovf_in      = 1'b0;
      end

      rsp_vld_in = rsp_load || (rsp_vld_ff && !rsp_ready);
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.load && !store_full) begin
         store_ff[byte_cnt_ff[ADR_W-1:0]] <= req_data.in_byte;
      end
      if (adv) begin
         rd_data_ff <= store_ff[idx_ff[ADR_W-1:0]];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff <= '0;
         ovf_ff      <= 1'b0;
         s0_vld_ff   <= 1'b0;
         s1_vld_ff   <= 1'b0;
         p_vld_ff    <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         byte_cnt_ff <= byte_cnt_in;
         ovf_ff      <= ovf_in;
         s0_vld_ff   <= s0_vld_in;
         s1_vld_ff   <= s1_vld_in;
         p_vld_ff    <= p_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rows_ff    <= rows_in;
      dec_ff     <= dec_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      prod_ff    <= prod_in;
      inner_ff   <= inner_in;
      outer_ff   <= outer_in;
      idx_ff     <= idx_in;
      s1_in_ff   <= s1_in_in;
      p_byte_ff  <= p_byte_in;
      rsp_ff     <= rsp_in;
   end

   assign stat.div_done   = (div_cnt_ff == DCNT_W'(NUM_W - 1));
   assign stat.overflow   = ovf_ff;
   assign stat.grid_big   = !dec_ff && (prod_ff > PROD_W'(MAX_LEN));
   assign stat.scan_empty = !s0_vld_ff && !s1_vld_ff;
   assign stat.adv        = adv;

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/row_transposition_cipher_core.sv =====
// top level of the row transposition cipher core: csr, controller, datapath
// loading takes one input word per cycle; the last word starts setup, the column
// count divider and the check, then, if it passes, a scan of all rows * columns
// grid cells, one per cycle unless the output stalls, then the closing word
// reset is synchronous, active high: control state cleared, row_count 1, encrypt
// mode; the message store is not cleared and needs no clearing pass
`include "row_transposition_cipher_core_defines.svh"

module row_transposition_cipher_core #(
   parameter int MAX_LEN = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rtc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rtc_pkg::rsp_type  rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import rtc_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   // configuration registers
   rtc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer
   rtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.in_last),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store, divider and scan
   rtc_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // checks
   `RTC_ASSERT_NEXT(a_last_stops_load, clock, reset, req_valid && req_ready && req_data.in_last, !req_ready, "input still taken after last word")
   `RTC_ASSERT_NEXT(a_prep_then_div, clock, reset, cmd.prep, cmd.div_step, "divider not stepped after setup")
   `RTC_ASSERT_NEXT(a_final_word, clock, reset, cmd.final_emit && stat.adv, rsp_valid && rsp_data.out_last, "closing word not presented")
   `RTC_ASSERT_SAME(a_error_is_last, clock, reset, rsp_valid && (rsp_data.status != STAT_OK), rsp_data.out_last && (rsp_data.out_byte == 8'd0), "error word malformed")

endmodule
